// File: rtl/cglr_pkg.sv
// cglr_pkg: widths, register indexes, reset values and the command word
// passed from the front end to the cell walker of the line rasterizer
// depends on nothing
package cglr_pkg;

   localparam int RowW      = 4;
   localparam int ColW      = 5;
   localparam int CharW     = 8;
   localparam int CntW      = 5;
   localparam int ErrW      = 8;
   localparam int LimW      = 9;
   localparam int RowsRegW  = 5;
   localparam int ColsRegW  = 6;
   localparam int CsrIdxW   = 4;
   localparam int CsrDataW  = 6;

   localparam logic [CsrIdxW-1:0]  CsrRowsInUse = 4'd0;
   localparam logic [CsrIdxW-1:0]  CsrColsInUse = 4'd1;

   localparam logic [RowsRegW-1:0] RowsInUseRst = 5'd10;
   localparam logic [ColsRegW-1:0] ColsInUseRst = 6'd20;

   localparam int QueueDepth = 2;
   localparam int QPtrW      = 1;
   localparam int QCntW      = 2;

   // one line, already reduced to a walk: start cell, step directions,
   // cell count minus one and the rounding slope d_minor / d_major
   typedef struct packed {
      logic [RowW-1:0]  row;
      logic [ColW-1:0]  col;
      logic             row_major;
      logic             major_dec;
      logic             minor_dec;
      logic [CntW-1:0]  count;
      logic [CntW-1:0]  d_major;
      logic [CntW-1:0]  d_minor;
      logic [CharW-1:0] fill;
   } cglr_cmd_type;

endpackage

// File: rtl/cglr_if.sv
// cglr channel interfaces: line request, cell write and register write words
// depends on cglr_pkg
interface cglr_req_if;
   logic                      valid;
   logic                      ready;
   logic [cglr_pkg::RowW-1:0]  start_row;
   logic [cglr_pkg::ColW-1:0]  start_col;
   logic [cglr_pkg::RowW-1:0]  end_row;
   logic [cglr_pkg::ColW-1:0]  end_col;
   logic [cglr_pkg::CharW-1:0] fill_char;

   modport source (output valid, start_row, start_col, end_row, end_col, fill_char,
                   input ready);
   modport sink   (input valid, start_row, start_col, end_row, end_col, fill_char,
                   output ready);
endinterface

interface cglr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [cglr_pkg::RowW-1:0]  pixel_row;
   logic [cglr_pkg::ColW-1:0]  pixel_col;
   logic [cglr_pkg::CharW-1:0] pixel_char;
   logic                      last;

   modport source (output valid, pixel_row, pixel_col, pixel_char, last, input ready);
   modport sink   (input valid, pixel_row, pixel_col, pixel_char, last, output ready);
endinterface

interface cglr_csr_if;
   logic                         valid;
   logic                         ready;
   logic [cglr_pkg::CsrIdxW-1:0]  index;
   logic [cglr_pkg::CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/char_grid_line_rasterizer.sv
// char_grid_line_rasterizer: top level of the character grid line rasterizer
// depends on cglr_pkg, cglr_if, cglr_front, cglr_cmd_fifo and cglr_back
//
//  channel    dir  word                                              handshake
//  req_chan   in   start_row, start_col, end_row, end_col, fill_char valid/ready
//  rsp_chan   out  pixel_row, pixel_col, pixel_char, last            valid/ready
//  csr_chan   in   index, data (0: rows_in_use, 1: cols_in_use)      valid/ready
//
// the cell walker sets the rate: it loads a line, then walks it at one cell
// per cycle while the output register is free, and loads the next line only
// after the last cell; the front end drops a line with an endpoint off the grid
// the front end keeps taking lines while the two-entry queue has room
// the walker stalls only when the output register holds an untaken word
// synchronous active-high reset empties queue and walker, grid size 10 x 20
module char_grid_line_rasterizer #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 32
) (
   input  logic       clock,
   input  logic       reset,
   cglr_req_if.sink   req_chan,
   cglr_rsp_if.source rsp_chan,
   cglr_csr_if.sink   csr_chan
);

   // front end to queue
   logic                   cmd_push;
   logic                   cmd_full;
   cglr_pkg::cglr_cmd_type cmd_push_data;

   // queue to cell walker
   logic                   cmd_pop;
   logic                   cmd_valid;
   cglr_pkg::cglr_cmd_type cmd_pop_data;

   // bounds check, classification and grid size registers
   cglr_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_push_data)
   );

   // decouples the front end from the walker
   cglr_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .pop_data  (cmd_pop_data)
   );

   // walks the cells and drives the output register
   cglr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_pop_data),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: rtl/cglr_front.sv
// cglr_front: grid size registers, bounds check and line classification
// depends on cglr_pkg and cglr_if
module cglr_front #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   cglr_req_if.sink               req_chan,
   cglr_csr_if.sink               csr_chan,
   input  logic                   cmd_full,
   output logic                   cmd_push,
   output cglr_pkg::cglr_cmd_type cmd_data
);

   localparam logic [cglr_pkg::LimW-1:0] MaxRowsC = cglr_pkg::LimW'(MAX_ROWS);
   localparam logic [cglr_pkg::LimW-1:0] MaxColsC = cglr_pkg::LimW'(MAX_COLS);

   logic [cglr_pkg::RowsRegW-1:0] rows_ff, rows_in;
   logic [cglr_pkg::ColsRegW-1:0] cols_ff, cols_in;
   logic [cglr_pkg::LimW-1:0]     rows_ext, cols_ext, row_lim, col_lim;
   logic                          outside, straight, along_col, row_major, fwd;
   logic signed [cglr_pkg::CntW:0] dr, dc;
   logic [cglr_pkg::CntW-1:0]     adr, adc, s_maj, e_maj;
   logic                          min_neg;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            cglr_pkg::CsrRowsInUse: rows_in = csr_chan.data[cglr_pkg::RowsRegW-1:0];
            cglr_pkg::CsrColsInUse: cols_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= cglr_pkg::RowsInUseRst;
         cols_ff <= cglr_pkg::ColsInUseRst;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // effective grid size, clamped to the build limits
   assign rows_ext = cglr_pkg::LimW'(rows_ff);
   assign cols_ext = cglr_pkg::LimW'(cols_ff);
   assign row_lim  = (rows_ext > MaxRowsC) ? MaxRowsC : rows_ext;
   assign col_lim  = (cols_ext > MaxColsC) ? MaxColsC : cols_ext;

   assign outside = (cglr_pkg::LimW'(req_chan.start_row) >= row_lim)
                 || (cglr_pkg::LimW'(req_chan.end_row)   >= row_lim)
                 || (cglr_pkg::LimW'(req_chan.start_col) >= col_lim)
                 || (cglr_pkg::LimW'(req_chan.end_col)   >= col_lim);

   assign dr  = $signed({2'b00, req_chan.end_row}) - $signed({2'b00, req_chan.start_row});
   assign dc  = $signed({1'b0, req_chan.end_col})  - $signed({1'b0, req_chan.start_col});
   assign adr = dr[cglr_pkg::CntW] ? cglr_pkg::CntW'(-dr) : dr[cglr_pkg::CntW-1:0];
   assign adc = dc[cglr_pkg::CntW] ? cglr_pkg::CntW'(-dc) : dc[cglr_pkg::CntW-1:0];

   assign along_col = (req_chan.start_row == req_chan.end_row);
   assign straight  = along_col || (req_chan.start_col == req_chan.end_col);
   assign row_major = adr > adc;
   assign s_maj     = row_major ? cglr_pkg::CntW'(req_chan.start_row) : req_chan.start_col;
   assign e_maj     = row_major ? cglr_pkg::CntW'(req_chan.end_row)   : req_chan.end_col;
   assign fwd       = s_maj < e_maj;
   assign min_neg   = row_major ? dc[cglr_pkg::CntW] : dr[cglr_pkg::CntW];

   always_comb begin
      cmd_data.fill = req_chan.fill_char;
      if (straight) begin
         cmd_data.row       = req_chan.start_row;
         cmd_data.col       = req_chan.start_col;
         cmd_data.row_major = !along_col;
         cmd_data.major_dec = along_col ? dc[cglr_pkg::CntW] : dr[cglr_pkg::CntW];
         cmd_data.minor_dec = 1'b0;
         cmd_data.count     = along_col ? adc : adr;
         cmd_data.d_major   = cglr_pkg::CntW'(1);
         cmd_data.d_minor   = '0;
      end else begin
         // walk from the smaller major end; the minor value there is exact
         cmd_data.row       = fwd ? req_chan.start_row : req_chan.end_row;
         cmd_data.col       = fwd ? req_chan.start_col : req_chan.end_col;
         cmd_data.row_major = row_major;
         cmd_data.major_dec = 1'b0;
         cmd_data.minor_dec = min_neg ^ !fwd;
         cmd_data.count     = row_major ? adr : adc;
         cmd_data.d_major   = row_major ? adr : adc;
         cmd_data.d_minor   = row_major ? adc : adr;
      end
   end

   assign req_chan.ready = !cmd_full;
   assign cmd_push       = req_chan.valid && !cmd_full && !outside;

endmodule

// File: rtl/cglr_cmd_fifo.sv
// cglr_cmd_fifo: short command queue between front end and cell walker
// depends on cglr_pkg
module cglr_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cglr_pkg::cglr_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output cglr_pkg::cglr_cmd_type pop_data
);

   cglr_pkg::cglr_cmd_type       slot_ff [cglr_pkg::QueueDepth];
   logic [cglr_pkg::QPtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [cglr_pkg::QCntW-1:0]   cnt_ff, cnt_in;
   logic                         do_push, do_pop;

   assign full      = (cnt_ff == cglr_pkg::QCntW'(cglr_pkg::QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/cglr_back.sv
// cglr_back: cell walker, one cell per cycle while the output register is free,
// with an error accumulator, feeding a registered cell write output
// depends on cglr_pkg and cglr_if
module cglr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  cglr_pkg::cglr_cmd_type cmd_data,
   output logic                   cmd_pop,
   cglr_rsp_if.source             rsp_chan
);

   logic                          busy_ff, busy_in;
   cglr_pkg::cglr_cmd_type        cmd_ff, cmd_in;
   logic signed [cglr_pkg::ErrW-1:0] err_ff, err_in, two_d, two_t, sum, dif;
   logic                          out_valid_ff, out_valid_in;
   logic [cglr_pkg::RowW-1:0]     out_row_ff, out_row_in;
   logic [cglr_pkg::ColW-1:0]     out_col_ff, out_col_in;
   logic [cglr_pkg::CharW-1:0]    out_char_ff, out_char_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_free, emit, minor_up, minor_dn;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign emit     = busy_ff && out_free;
   assign cmd_pop  = !busy_ff && cmd_valid;

   assign two_d = $signed({2'b00, cmd_ff.d_major, 1'b0});
   assign two_t = $signed({2'b00, cmd_ff.d_minor, 1'b0});
   assign sum   = err_ff + two_t;
   assign dif   = err_ff - two_t;
   assign minor_up = !cmd_ff.minor_dec && (sum >= two_d);
   assign minor_dn = cmd_ff.minor_dec && (dif < 0);

   always_comb begin
      busy_in      = busy_ff;
      cmd_in       = cmd_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd_pop) begin
         busy_in = 1'b1;
         cmd_in  = cmd_data;
         err_in  = $signed({3'b000, cmd_data.d_major});
      end else if (emit) begin
         out_valid_in = 1'b1;
         out_row_in   = cmd_ff.row;
         out_col_in   = cmd_ff.col;
         out_char_in  = cmd_ff.fill;
         out_last_in  = (cmd_ff.count == '0);
         busy_in      = (cmd_ff.count != '0);
         cmd_in.count = cmd_ff.count - 1'b1;
         // rounding remainder stays in [0, 2*d_major)
         if (cmd_ff.minor_dec) begin
            err_in = minor_dn ? dif + two_d : dif;
         end else begin
            err_in = minor_up ? sum - two_d : sum;
         end
         if (cmd_ff.row_major) begin
            cmd_in.row = cmd_ff.major_dec ? cmd_ff.row - 1'b1 : cmd_ff.row + 1'b1;
            if (minor_up) begin
               cmd_in.col = cmd_ff.col + 1'b1;
            end else if (minor_dn) begin
               cmd_in.col = cmd_ff.col - 1'b1;
            end
         end else begin
            cmd_in.col = cmd_ff.major_dec ? cmd_ff.col - 1'b1 : cmd_ff.col + 1'b1;
            if (minor_up) begin
               cmd_in.row = cmd_ff.row + 1'b1;
            end else if (minor_dn) begin
               cmd_in.row = cmd_ff.row - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      err_ff      <= err_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_row  = out_row_ff;
   assign rsp_chan.pixel_col  = out_col_ff;
   assign rsp_chan.pixel_char = out_char_ff;
   assign rsp_chan.last       = out_last_ff;

endmodule
